// ===== rtl/hlfr_pkg.sv =====
// Shared constants and functions of the heading-locked frame rotator.
`timescale 1ns / 1ps
package hlfr_pkg;

  localparam int AtanEntries = 24;
  localparam int IntW        = 34;
  localparam int AngW        = 33;

  localparam logic signed [AngW-1:0] HalfPiU = 33'sd1073741824;
  localparam logic signed [AngW-1:0] PiU     = 33'sd2147483648;
  localparam logic signed [IntW-1:0] CordicKQ30 = 34'sd652032874;
  localparam logic signed [IntW-1:0] OneQ28     = 34'sd268435456;

  localparam logic ActAttitude = 1'b0;
  localparam logic ActVelocity = 1'b1;

  // arctan(2^-i) in units of pi/2^31
  function automatic logic [29:0] atan_unit(input logic [4:0] idx);
    logic [29:0] v;
    begin
      case (idx)
        5'd0:  v = 30'd536870912;
        5'd1:  v = 30'd316933406;
        5'd2:  v = 30'd167458907;
        5'd3:  v = 30'd85004756;
        5'd4:  v = 30'd42667331;
        5'd5:  v = 30'd21354465;
        5'd6:  v = 30'd10679838;
        5'd7:  v = 30'd5340245;
        5'd8:  v = 30'd2670163;
        5'd9:  v = 30'd1335087;
        5'd10: v = 30'd667544;
        5'd11: v = 30'd333772;
        5'd12: v = 30'd166886;
        5'd13: v = 30'd83443;
        5'd14: v = 30'd41722;
        5'd15: v = 30'd20861;
        5'd16: v = 30'd10430;
        5'd17: v = 30'd5215;
        5'd18: v = 30'd2608;
        5'd19: v = 30'd1304;
        5'd20: v = 30'd652;
        5'd21: v = 30'd326;
        5'd22: v = 30'd163;
        5'd23: v = 30'd81;
        default: v = 30'd0;
      endcase
      return v;
    end
  endfunction

endpackage

// ===== rtl/heading_locked_frame_rotator_core.sv =====
// Top level of the heading-locked frame rotator.
`timescale 1ns / 1ps
// Every request returns one result. A velocity request after the lock sends four products
// through one shared multiplier, two per output axis. A velocity request before the lock
// is answered from the idle state without any products. The first attitude request runs
// the quaternion products, a CORDIC vectoring pass and a CORDIC rotation pass through one
// shared shift-add unit; the vectoring pass is skipped when the yaw numerator and
// denominator are both zero. Later attitude requests are answered from the stored values
// without any passes. Input ready is low while a request is in work or while its result
// waits at the output register. Input ready comes back in the cycle after the result is
// taken.
module heading_locked_frame_rotator_core #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // tdata: quat_w, quat_x, quat_y, quat_z, vel_fwd, vel_left, vel_up (low bit up)
  input  logic [111:0] s_tdata,
  // tuser: action
  input  logic         s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // tdata: vel_north, vel_east, vel_down, heading_locked, yaw_angle (low bit up)
  output logic [71:0]  m_tdata
);

  localparam int NSteps = (CORDIC_STEPS > hlfr_pkg::AtanEntries) ?
                          hlfr_pkg::AtanEntries : CORDIC_STEPS;
  localparam int IW = hlfr_pkg::IntW;
  localparam int AW = hlfr_pkg::AngW;

  typedef enum logic [3:0] {
    S_IDLE, S_MUL0, S_MUL1, S_MUL2, S_MUL3, S_VSETUP, S_VEC, S_ROUND,
    S_RSETUP, S_ROT, S_STORE, S_VMUL0, S_VMUL1, S_VSUM, S_OUT, S_VFIN
  } state_t;

  state_t state;
  logic [4:0] step;
  logic signed [15:0] qw, qx, qy, qz, vf, vl, vu;
  logic signed [IW-1:0] cx, cy, acc;
  logic signed [AW-1:0] cz;
  logic flip;
  logic signed [31:0] prod;
  logic signed [15:0] yaw_store, cos_store, sin_store;
  logic lock_flag;
  logic signed [15:0] vn, ve, vd;

  logic signed [15:0] ma, mb;
  logic signed [31:0] mprod;
  logic signed [IW-1:0] xs, ys;
  logic dir;
  logic signed [AW-1:0] tz;
  logic signed [15:0] rnd_c, rnd_s;
  logic [31:0] ang;
  logic signed [IW-1:0] den;
  logic signed [AW-1:0] yz;

  // shared multiplier operand select
  always_comb begin
    ma = qw;
    mb = qz;
    unique case (state)
      S_MUL1:  begin ma = qx; mb = qy; end
      S_MUL2:  begin ma = qy; mb = qy; end
      S_MUL3:  begin ma = qz; mb = qz; end
      S_VMUL0: begin ma = cos_store; mb = vf; end
      S_VMUL1: begin ma = sin_store; mb = vl; end
      S_VSUM:  begin ma = sin_store; mb = vf; end
      S_OUT:   begin ma = cos_store; mb = vl; end
      default: begin ma = qw; mb = qz; end
    endcase
    mprod = ma * mb;
  end

  assign tz = $signed({3'b000, hlfr_pkg::atan_unit(step)});
  assign xs = cx >>> step;
  assign ys = cy >>> step;
  assign dir = (state == S_VEC) ? ~cy[IW-1] : ~cz[AW-1];
  assign ang = cz[31:0] + 32'h8000;
  assign den = hlfr_pkg::OneQ28 - ((acc + IW'(prod)) <<< 1);
  assign yz = AW'(yaw_store) <<< 16;

  function automatic logic signed [15:0] q30_q14(input logic signed [IW-1:0] v);
    logic signed [IW-1:0] r;
    begin
      r = (v + IW'(8192)) >>> 16;
      if (r > IW'(16384)) r = IW'(16384);
      else if (r < -IW'(16384)) r = -IW'(16384);
      return r[15:0];
    end
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [IW-1:0] v);
    begin
      if (v > IW'(32767)) return 16'sh7fff;
      if (v < -IW'(32768)) return 16'sh8000;
      return v[15:0];
    end
  endfunction

  assign rnd_c = q30_q14(flip ? -cx : cx);
  assign rnd_s = q30_q14(flip ? -cy : cy);

  assign s_tready = (state == S_IDLE) && !m_tvalid;

  always_ff @(posedge clk) begin
    prod <= mprod;
    if (rst) begin
      state <= S_IDLE;
      m_tvalid <= 1'b0;
      lock_flag <= 1'b0;
      yaw_store <= '0;
      cos_store <= 16'sd16384;
      sin_store <= '0;
      vn <= '0; ve <= '0; vd <= '0;
      step <= '0;
    end else begin
      if (m_tvalid && m_tready) m_tvalid <= 1'b0;
      unique case (state)
        S_IDLE: if (s_tvalid && s_tready) begin
          {vu, vl, vf, qz, qy, qx, qw} <= s_tdata;
          if (s_tuser == hlfr_pkg::ActAttitude) begin
            if (lock_flag) m_tvalid <= 1'b1;
            else state <= S_MUL0;
          end else if (!lock_flag) begin
            vn <= '0; ve <= '0; vd <= '0;
            m_tvalid <= 1'b1;
          end else state <= S_VMUL0;
        end
        S_MUL0: state <= S_MUL1;
        S_MUL1: begin acc <= IW'(prod); state <= S_MUL2; end
        S_MUL2: begin cy <= (acc + IW'(prod)) <<< 1; state <= S_MUL3; end
        S_MUL3: begin acc <= IW'(prod); state <= S_VSETUP; end
        S_VSETUP: begin
          step <= '0;
          if (den == '0 && cy == '0) begin
            cz <= '0;
            state <= S_ROUND;
          end else begin
            state <= S_VEC;
            // pre-rotate by pi when the denominator is negative
            if (den < 0) begin
              cx <= -den;
              cy <= -cy;
              cz <= hlfr_pkg::PiU;
            end else begin
              cx <= den;
              cz <= '0;
            end
          end
        end
        S_VEC: begin
          if (dir) begin cx <= cx + ys; cy <= cy - xs; cz <= cz + tz; end
          else begin cx <= cx - ys; cy <= cy + xs; cz <= cz - tz; end
          step <= step + 5'd1;
          if (step == 5'(NSteps - 1)) state <= S_ROUND;
        end
        S_ROUND: begin
          yaw_store <= ang[31:16];
          state <= S_RSETUP;
        end
        S_RSETUP: begin
          step <= '0;
          cx <= hlfr_pkg::CordicKQ30;
          cy <= '0;
          state <= S_ROT;
          if (yz > hlfr_pkg::HalfPiU) begin
            cz <= yz - hlfr_pkg::PiU; flip <= 1'b1;
          end else if (yz < -hlfr_pkg::HalfPiU) begin
            cz <= yz + hlfr_pkg::PiU; flip <= 1'b1;
          end else begin
            cz <= yz; flip <= 1'b0;
          end
        end
        S_ROT: begin
          if (dir) begin cx <= cx - ys; cy <= cy + xs; cz <= cz - tz; end
          else begin cx <= cx + ys; cy <= cy - xs; cz <= cz + tz; end
          step <= step + 5'd1;
          if (step == 5'(NSteps - 1)) state <= S_STORE;
        end
        S_STORE: begin
          cos_store <= rnd_c;
          sin_store <= rnd_s;
          lock_flag <= 1'b1;
          m_tvalid <= 1'b1;
          state <= S_IDLE;
        end
        S_VMUL0: state <= S_VMUL1;
        S_VMUL1: begin acc <= IW'(prod); state <= S_VSUM; end
        S_VSUM: begin
          vn <= sat16((acc + IW'(prod) + IW'(8192)) >>> 14);
          state <= S_OUT;
        end
        S_OUT: begin
          // s*f arrives now; c*l was launched this cycle, finish next
          acc <= IW'(prod);
          vd <= sat16(-IW'(vu));
          state <= S_VFIN;
        end
        S_VFIN: begin
          ve <= sat16((acc - IW'(prod) + IW'(8192)) >>> 14);
          m_tvalid <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign m_tdata = {7'd0, yaw_store, lock_flag, vd, ve, vn};

endmodule
